// ===== rtl/core/gcd_lcm_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit assertion macros
// concurrent check helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GLU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit: same-cycle check failed");

// next-cycle implication
`define GLU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit: next-cycle check failed");

`else

`define GLU_ASSERT_IMP(label, ante, cons)
`define GLU_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/glu_pkg.sv =====
// ----------------------------------------------------------------------------
// glu_pkg
// shared types and codes for the gcd / lcm unit
// ----------------------------------------------------------------------------
`default_nettype none

package glu_pkg;

  // fixed field widths of the item payload
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned MULTIPLE_W = 64;

  // datapath operation codes
  typedef logic [3:0] op_t;
  localparam op_t OP_HOLD    = 4'd0;
  localparam op_t OP_LOAD    = 4'd1;
  localparam op_t OP_TWO     = 4'd2;  // strip a common factor of two
  localparam op_t OP_RED     = 4'd3;  // binary gcd reduction step
  localparam op_t OP_SHL     = 4'd4;  // put the factors of two back
  localparam op_t OP_DIVINIT = 4'd5;
  localparam op_t OP_DIV     = 4'd6;  // one restoring divide step
  localparam op_t OP_MULINIT = 4'd7;
  localparam op_t OP_MUL     = 4'd8;  // one shift-add multiply step

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic load_out;
    logic idle;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic zero_in;
    logic both_even;
    logic x_eq_y;
    logic k_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/glu_seq.sv =====
// ----------------------------------------------------------------------------
// glu_seq
// sequencer driving the shared add/subtract datapath through gcd, divide, multiply
// ----------------------------------------------------------------------------
`default_nettype none

module glu_seq #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           out_free,
  input  wire glu_pkg::stat_t stat,
  output glu_pkg::ctrl_t      ctrl
);

  localparam int unsigned CW = $clog2(OPERAND_WIDTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TWO  = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_SHL  = 4'd3;
  localparam logic [3:0] S_DIVI = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MULI = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cnt_last;

  assign cnt_last = (cnt_r == CW'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctrl.op       = glu_pkg::OP_HOLD;
    ctrl.load_out = 1'b0;
    ctrl.idle     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.idle = 1'b1;
        if (start) begin
          ctrl.op   = glu_pkg::OP_LOAD;
          state_nxt = stat.zero_in ? S_DONE : S_TWO;
        end
      end
      S_TWO: begin
        if (stat.both_even) begin
          ctrl.op = glu_pkg::OP_TWO;
        end else begin
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (stat.x_eq_y) begin
          state_nxt = S_SHL;
        end else begin
          ctrl.op = glu_pkg::OP_RED;
        end
      end
      S_SHL: begin
        if (stat.k_zero) begin
          state_nxt = S_DIVI;
        end else begin
          ctrl.op = glu_pkg::OP_SHL;
        end
      end
      S_DIVI: begin
        ctrl.op   = glu_pkg::OP_DIVINIT;
        cnt_nxt   = CW'(OPERAND_WIDTH);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctrl.op = glu_pkg::OP_DIV;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_last) begin
          state_nxt = S_MULI;
        end
      end
      S_MULI: begin
        ctrl.op   = glu_pkg::OP_MULINIT;
        cnt_nxt   = CW'(OPERAND_WIDTH);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctrl.op = glu_pkg::OP_MUL;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/glu_dp.sv =====
// ----------------------------------------------------------------------------
// glu_dp
// operand registers around one shared add/subtract unit
// ----------------------------------------------------------------------------
`default_nettype none

module glu_dp #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire glu_pkg::ctrl_t             ctrl,
  input  wire logic [OPERAND_WIDTH-1:0]   in_a,
  input  wire logic [OPERAND_WIDTH-1:0]   in_b,
  output glu_pkg::stat_t                  stat,
  output logic [OPERAND_WIDTH-1:0]        res_divisor,
  output logic [2*OPERAND_WIDTH-1:0]      res_multiple,
  output logic                            res_zero
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned KW = $clog2(OPERAND_WIDTH);

  logic [W-1:0]  x_r, x_nxt;      // gcd work value, then the gcd itself
  logic [W-1:0]  y_r, y_nxt;      // gcd work value, then dividend/quotient
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  hi_r, hi_nxt;    // remainder, then upper product half
  logic [W-1:0]  lo_r, lo_nxt;
  logic [KW-1:0] k_r, k_nxt;      // common power of two
  logic          zero_r, zero_nxt;

  // shared adder / subtractor
  logic [W:0]   alu_a, alu_b, alu_b_eff;
  logic         alu_sub;
  logic [W+1:0] alu_res;
  logic         alu_ge;
  logic [W:0]   mul_sum;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.op)
      glu_pkg::OP_RED: begin
        alu_a   = {1'b0, x_r};
        alu_b   = {1'b0, y_r};
        alu_sub = 1'b1;
      end
      glu_pkg::OP_DIV: begin
        alu_a   = {hi_r, y_r[W-1]};
        alu_b   = {1'b0, x_r};
        alu_sub = 1'b1;
      end
      glu_pkg::OP_MUL: begin
        alu_a   = {1'b0, hi_r};
        alu_b   = {1'b0, b_r};
      end
      default: ;
    endcase
  end

  assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
  assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b_eff} + {{(W+1){1'b0}}, alu_sub};
  assign alu_ge    = alu_res[W+1];
  assign mul_sum   = y_r[0] ? alu_res[W:0] : {1'b0, hi_r};

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    k_nxt    = k_r;
    zero_nxt = zero_r;
    unique case (ctrl.op)
      glu_pkg::OP_HOLD: ;
      glu_pkg::OP_LOAD: begin
        x_nxt    = in_a;
        y_nxt    = in_b;
        a_nxt    = in_a;
        b_nxt    = in_b;
        k_nxt    = '0;
        zero_nxt = stat.zero_in;
      end
      glu_pkg::OP_TWO: begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + KW'(1);
      end
      glu_pkg::OP_RED: begin
        if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_ge) begin
          x_nxt = {1'b0, alu_res[W-1:1]};
        end else begin
          // larger value into x, smaller into y, subtract on the next step
          x_nxt = y_r;
          y_nxt = x_r;
        end
      end
      glu_pkg::OP_SHL: begin
        x_nxt = x_r << 1;
        k_nxt = k_r - KW'(1);
      end
      glu_pkg::OP_DIVINIT: begin
        hi_nxt = '0;
        y_nxt  = a_r;
      end
      glu_pkg::OP_DIV: begin
        if (alu_ge) begin
          hi_nxt = alu_res[W-1:0];
          y_nxt  = {y_r[W-2:0], 1'b1};
        end else begin
          hi_nxt = alu_a[W-1:0];
          y_nxt  = {y_r[W-2:0], 1'b0};
        end
      end
      glu_pkg::OP_MULINIT: begin
        hi_nxt = '0;
      end
      glu_pkg::OP_MUL: begin
        hi_nxt = mul_sum[W:1];
        lo_nxt = {mul_sum[0], lo_r[W-1:1]};
        y_nxt  = y_r >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    k_r    <= k_nxt;
    zero_r <= zero_nxt;
  end

  assign stat.zero_in   = (in_a == '0) || (in_b == '0);
  assign stat.both_even = !x_r[0] && !y_r[0];
  assign stat.x_eq_y    = (x_r == y_r);
  assign stat.k_zero    = (k_r == '0);

  assign res_divisor  = zero_r ? '0 : x_r;
  assign res_multiple = zero_r ? '0 : {hi_r, lo_r};
  assign res_zero     = zero_r;

endmodule

`default_nettype wire

// ===== rtl/core/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// greatest common divisor and least common multiple of two unsigned operands
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata (low bit up)                  tuser
//  in_      slave      operand_a[31:0], operand_b[63:32]   -
//  out_     master     divisor[31:0], multiple[95:32]      zero_operand
//
//  one item at a time; W = OPERAND_WIDTH
//  per item: binary gcd on the shared subtractor (incl. restoring the power
//  of two), then W restoring divide steps and W shift-add multiply steps on
//  the same unit; an item with a zero operand skips all of these steps
//  reset: synchronous, active low, clears the sequencer and the output valid
//  the finished result sits in an output register; a new item is taken while
//  it waits, and the next result waits in the sequencer until it is taken
//
`default_nettype none

`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // operand_a[31:0], operand_b[63:32]
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // divisor[31:0], multiple[95:32]
  output logic              out_tuser   // zero_operand
);

  localparam int unsigned W = OPERAND_WIDTH;

  glu_pkg::ctrl_t ctrl;
  glu_pkg::stat_t stat;

  logic [W-1:0]   op_a, op_b;
  logic [W-1:0]   res_divisor;
  logic [2*W-1:0] res_multiple;
  logic           res_zero;
  logic           in_accept;
  logic           out_free;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  logic [glu_pkg::FIELD_W-1:0]         out_divisor_r;
  logic [glu_pkg::MULTIPLE_W-1:0]      out_multiple_r;
  logic                                out_zero_r;

  // bits above the operand width are ignored
  assign op_a = in_tdata[W-1:0];
  assign op_b = in_tdata[glu_pkg::FIELD_W +: W];

  assign in_tready = ctrl.idle;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  glu_seq #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  glu_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .in_a         (op_a),
    .in_b         (op_b),
    .stat         (stat),
    .res_divisor  (res_divisor),
    .res_multiple (res_multiple),
    .res_zero     (res_zero)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_divisor_r  <= glu_pkg::FIELD_W'(res_divisor);
      out_multiple_r <= glu_pkg::MULTIPLE_W'(res_multiple);
      out_zero_r     <= res_zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_multiple_r, out_divisor_r};
  assign out_tuser  = out_zero_r;

  // sequencer leaves idle right after taking an item
  `GLU_ASSERT_NXT(a_busy_after_accept, in_accept, !in_tready)
  // zero operand flag forces both results to zero
  `GLU_ASSERT_IMP(a_zero_results, out_valid_r && out_zero_r, {out_divisor_r, out_multiple_r} == '0)
  // a gcd of nonzero operands is never zero
  `GLU_ASSERT_IMP(a_divisor_nonzero, out_valid_r && !out_zero_r, out_divisor_r != '0)
  // nor is their lcm
  `GLU_ASSERT_IMP(a_multiple_nonzero, out_valid_r && !out_zero_r, out_multiple_r != '0)

endmodule

`default_nettype wire
